>>> rtl/core/clook_pkg.sv
// ----------------------------------------------------------------------------
// clook_pkg
// Shared types and constants for the C-LOOK disk request queue.
// ----------------------------------------------------------------------------
package clook_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int AW          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW          = $clog2(QUEUE_DEPTH + 1);

    localparam int SECTOR_W = 48;
    localparam int TAG_W    = 8;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 6;

    localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DISP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REM  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_ADDED      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DISPATCHED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REMOVED    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ABSENT     = 3'd5;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_DISP,
        OP_REM,
        OP_BAD
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [SECTOR_W-1:0] sector;
        logic [TAG_W-1:0]    tag;
    } req_t;

    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [TAG_W-1:0]    tag;
    } entry_t;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_CHK,
        BS_UP_WR,
        BS_INS,
        BS_DISP_CHK,
        BS_DN_WR,
        BS_DROP_END,
        BS_DONE
    } back_state_t;

endpackage

>>> rtl/core/clook_disk_request_queue_top.sv
// ----------------------------------------------------------------------------
// clook_disk_request_queue_top
// C-LOOK ordered disk request queue: add, dispatch front, remove by tag.
// ----------------------------------------------------------------------------
// Throughput: one word at a time in the back end; the entry memory's single
//   write port moves one entry a cycle during a shift.
// Reset: queue empty, head before every sector; entry memory is not cleared.
// ----------------------------------------------------------------------------
module clook_disk_request_queue_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [clook_pkg::CMD_W-1:0]      cmd,
    input  logic [clook_pkg::SECTOR_W-1:0]   sector,
    input  logic [clook_pkg::TAG_W-1:0]      tag,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [clook_pkg::STATUS_W-1:0]   status,
    output logic [clook_pkg::SECTOR_W-1:0]   out_sector,
    output logic [clook_pkg::TAG_W-1:0]      out_tag,
    output logic [clook_pkg::COUNT_W-1:0]    count
);
    import clook_pkg::*;

    // decoded word queue between front and back
    logic q_valid;
    logic q_ready;
    req_t q_data;

    // front: takes words while the back end is still busy
    clook_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sector   (sector),
        .tag      (tag),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data)
    );

    // back: scans and shifts the ordered entry memory, result held in a register
    clook_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_data     (q_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .out_sector (out_sector),
        .out_tag    (out_tag),
        .count      (count)
    );

endmodule

>>> rtl/core/clook_front.sv
// ----------------------------------------------------------------------------
// clook_front
// Accepts command words, decodes them and holds them in a two-word queue.
// ----------------------------------------------------------------------------
module clook_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [clook_pkg::CMD_W-1:0]    cmd,
    input  logic [clook_pkg::SECTOR_W-1:0] sector,
    input  logic [clook_pkg::TAG_W-1:0]    tag,
    output logic                          q_valid,
    input  logic                          q_ready,
    output clook_pkg::req_t               q_data
);
    import clook_pkg::*;

    req_t       slot_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] fill_reg, fill_next;
    req_t       dec;
    logic       push, pop;

    always_comb
    begin
        unique case (cmd)
            CMD_ADD:  dec.op = OP_ADD;
            CMD_DISP: dec.op = OP_DISP;
            CMD_REM:  dec.op = OP_REM;
            default:  dec.op = OP_BAD;
        endcase
        dec.sector = sector;
        dec.tag    = tag;
    end

    assign in_ready = (fill_reg != 2'd2);
    assign q_valid  = (fill_reg != 2'd0);
    assign q_data   = slot_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wp_next   = wp_reg ^ push;
        rp_next   = rp_reg ^ pop;
        fill_next = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= dec;
        end
    end

endmodule

>>> rtl/core/clook_back.sv
// ----------------------------------------------------------------------------
// clook_back
// Carries out queued commands on the ordered entry memory, one entry a cycle.
// ----------------------------------------------------------------------------
module clook_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  clook_pkg::req_t                 q_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [clook_pkg::STATUS_W-1:0]   status,
    output logic [clook_pkg::SECTOR_W-1:0]   out_sector,
    output logic [clook_pkg::TAG_W-1:0]      out_tag,
    output logic [clook_pkg::COUNT_W-1:0]    count
);
    import clook_pkg::*;

    entry_t mem [QUEUE_DEPTH];
    entry_t rd_data_reg;
    logic   we;
    logic [AW-1:0] wa, ra;
    entry_t wd;

    back_state_t state_reg, state_next;
    req_t        req_reg, req_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [CW-1:0] count_reg, count_next;
    logic [SECTOR_W-1:0] head_reg, head_next;
    logic known_reg, known_next;
    logic above_reg, above_next;
    logic eq_reg, eq_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [SECTOR_W-1:0] res_sector_reg, res_sector_next;
    logic [TAG_W-1:0]    res_tag_reg, res_tag_next;
    logic out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [SECTOR_W-1:0] out_sector_reg, out_sector_next;
    logic [TAG_W-1:0]    out_tag_reg, out_tag_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;

    logic e_above, e_below, r_less, hit, last;

    // entry position relative to head
    always_comb
    begin
        e_above = !known_reg || (rd_data_reg.sector > head_reg);
        e_below = known_reg && (rd_data_reg.sector < head_reg);
        r_less  = req_reg.sector < rd_data_reg.sector;
        if (req_reg.op == OP_ADD)
        begin
            hit = above_reg ? ((e_above && r_less) || e_below)
                            : ((e_below && r_less) || eq_reg);
        end
        else
        begin
            hit = (rd_data_reg.tag == req_reg.tag);
        end
        last = (CW'(idx_reg) + CW'(1)) == count_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        known_next      = known_reg;
        above_next      = above_reg;
        eq_next         = eq_reg;
        res_status_next = res_status_reg;
        res_sector_next = res_sector_reg;
        res_tag_next    = res_tag_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_sector_next = out_sector_reg;
        out_tag_next    = out_tag_reg;
        out_count_next  = out_count_reg;
        q_ready         = 1'b0;
        we              = 1'b0;
        wa              = idx_reg;
        wd              = rd_data_reg;
        ra              = idx_reg;

        unique case (state_reg)
            BS_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    req_next        = q_data;
                    res_sector_next = '0;
                    res_tag_next    = '0;
                    above_next      = !known_reg || (q_data.sector > head_reg);
                    eq_next         = known_reg && (q_data.sector == head_reg);
                    idx_next        = '0;
                    ra              = '0;
                    unique case (q_data.op)
                        OP_ADD:
                        begin
                            if (count_reg == CW'(QUEUE_DEPTH))
                            begin
                                res_status_next = ST_FULL;
                                state_next      = BS_DONE;
                            end
                            else if (count_reg == '0)
                            begin
                                pos_next   = '0;
                                state_next = BS_INS;
                            end
                            else
                            begin
                                state_next = BS_CHK;
                            end
                        end
                        OP_DISP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                                state_next      = BS_DONE;
                            end
                            else
                            begin
                                state_next = BS_DISP_CHK;
                            end
                        end
                        OP_REM:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_ABSENT;
                                state_next      = BS_DONE;
                            end
                            else
                            begin
                                state_next = BS_CHK;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_ABSENT;
                            state_next      = BS_DONE;
                        end
                    endcase
                end
            end
            BS_CHK:
            begin
                if (hit)
                begin
                    pos_next = idx_reg;
                    if (req_reg.op == OP_ADD)
                    begin
                        idx_next   = AW'(count_reg);
                        ra         = AW'(count_reg - CW'(1));
                        state_next = BS_UP_WR;
                    end
                    else if (!last)
                    begin
                        ra         = idx_reg + AW'(1);
                        state_next = BS_DN_WR;
                    end
                    else
                    begin
                        state_next = BS_DROP_END;
                    end
                end
                else if (last)
                begin
                    if (req_reg.op == OP_ADD)
                    begin
                        pos_next   = AW'(count_reg);
                        state_next = BS_INS;
                    end
                    else
                    begin
                        res_status_next = ST_ABSENT;
                        state_next      = BS_DONE;
                    end
                end
                else
                begin
                    ra       = idx_reg + AW'(1);
                    idx_next = idx_reg + AW'(1);
                end
            end
            BS_UP_WR:
            begin
                we = 1'b1;
                wa = idx_reg;
                wd = rd_data_reg;
                if ((idx_reg - AW'(1)) == pos_reg)
                begin
                    state_next = BS_INS;
                end
                else
                begin
                    ra       = idx_reg - AW'(2);
                    idx_next = idx_reg - AW'(1);
                end
            end
            BS_INS:
            begin
                we              = 1'b1;
                wa              = pos_reg;
                wd.sector       = req_reg.sector;
                wd.tag          = req_reg.tag;
                count_next      = count_reg + CW'(1);
                res_status_next = ST_ADDED;
                state_next      = BS_DONE;
            end
            BS_DISP_CHK:
            begin
                res_sector_next = rd_data_reg.sector;
                res_tag_next    = rd_data_reg.tag;
                head_next       = rd_data_reg.sector;
                known_next      = 1'b1;
                idx_next        = '0;
                if (count_reg > CW'(1))
                begin
                    ra         = AW'(1);
                    state_next = BS_DN_WR;
                end
                else
                begin
                    state_next = BS_DROP_END;
                end
            end
            BS_DN_WR:
            begin
                we = 1'b1;
                wa = idx_reg;
                wd = rd_data_reg;
                if ((CW'(idx_reg) + CW'(2)) == count_reg)
                begin
                    state_next = BS_DROP_END;
                end
                else
                begin
                    ra       = idx_reg + AW'(2);
                    idx_next = idx_reg + AW'(1);
                end
            end
            BS_DROP_END:
            begin
                count_next      = count_reg - CW'(1);
                res_status_next = (req_reg.op == OP_DISP) ? ST_DISPATCHED : ST_REMOVED;
                state_next      = BS_DONE;
            end
            BS_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_sector_next = res_sector_reg;
                    out_tag_next    = res_tag_reg;
                    out_count_next  = COUNT_W'(count_reg);
                    state_next      = BS_IDLE;
                end
            end
            default:
            begin
                state_next = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BS_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            known_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            known_reg     <= known_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        above_reg      <= above_next;
        eq_reg         <= eq_next;
        res_status_reg <= res_status_next;
        res_sector_reg <= res_sector_next;
        res_tag_reg    <= res_tag_next;
        out_status_reg <= out_status_next;
        out_sector_reg <= out_sector_next;
        out_tag_reg    <= out_tag_next;
        out_count_reg  <= out_count_next;
    end

    // entry memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[ra];
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign out_sector = out_sector_reg;
    assign out_tag    = out_tag_reg;
    assign count      = out_count_reg;

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives add, dispatch, remove and unused command words into the C-LOOK request queue, keeps
// its own ordered copy of the queue and head position, and checks every
// result word field by field against the predicted one.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import clook_pkg::*;

    localparam int STALL_PCT  = 29;
    localparam int IDLE_LIMIT = 20000;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [SECTOR_W-1:0] sector;
        logic [TAG_W-1:0]    tag;
        logic [COUNT_W-1:0]  count;
    } outcome_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [CMD_W-1:0]    cmd = '0;
    logic [SECTOR_W-1:0] sector = '0;
    logic [TAG_W-1:0]    tag = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [SECTOR_W-1:0] out_sector;
    logic [TAG_W-1:0]    out_tag;
    logic [COUNT_W-1:0]  count;

    // Mirror of the queue in service order, plus head position.
    logic [SECTOR_W-1:0] q_sector[$];
    logic [TAG_W-1:0]    q_tag[$];
    logic [SECTOR_W-1:0] head_pos = '0;
    bit                  head_set = 1'b0;

    outcome_t pending[$];
    int       errors = 0;
    int       idle_cycles = 0;
    bit       calm = 1'b0;   // set during the no-idling stretch

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    clook_disk_request_queue_top i_dut (.*);

    // -1 below head, 0 at head, 1 above; an unset head lies before all sectors
    function automatic int side_of(logic [SECTOR_W-1:0] s);
        if (!head_set) return 1;
        if (s < head_pos) return -1;
        if (s > head_pos) return 1;
        return 0;
    endfunction

    function automatic int clook_slot(logic [SECTOR_W-1:0] r);
        int rc;
        int ec;
        rc = side_of(r);
        foreach (q_sector[i])
        begin
            ec = side_of(q_sector[i]);
            if (rc > 0)
            begin
                if ((ec > 0 && r < q_sector[i]) || ec < 0) return i;
            end
            else if ((ec < 0 && r < q_sector[i]) || rc == 0)
                return i;
        end
        return q_sector.size();
    endfunction

    function automatic outcome_t queue_step(logic [CMD_W-1:0] c,
                                            logic [SECTOR_W-1:0] s,
                                            logic [TAG_W-1:0] t);
        outcome_t o;
        int       p;
        o = '{ST_ABSENT, '0, '0, '0};
        case (c)
            CMD_ADD:
                if (q_sector.size() >= QUEUE_DEPTH) o.status = ST_FULL;
                else
                begin
                    p = clook_slot(s);
                    q_sector.insert(p, s);
                    q_tag.insert(p, t);
                    o.status = ST_ADDED;
                end
            CMD_DISP:
                if (q_sector.size() == 0) o.status = ST_EMPTY;
                else
                begin
                    o.sector = q_sector.pop_front();
                    o.tag    = q_tag.pop_front();
                    head_pos = o.sector;
                    head_set = 1'b1;
                    o.status = ST_DISPATCHED;
                end
            CMD_REM:
                foreach (q_tag[i])
                    if (q_tag[i] == t)
                    begin
                        q_sector.delete(i);
                        q_tag.delete(i);
                        o.status = ST_REMOVED;
                        break;
                    end
            default: ;
        endcase
        o.count = COUNT_W'(q_sector.size());
        return o;
    endfunction

    // Send one word; the prediction is queued at the accepting edge.
    // Valid stays high after acceptance until the next idle cycle or the end.
    task automatic send_word(logic [CMD_W-1:0] c, logic [SECTOR_W-1:0] s,
                             logic [TAG_W-1:0] t);
        while (!calm && $urandom_range(99) < STALL_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        sector   <= s;
        tag      <= t;
        do @(posedge clk); while (!in_ready);
        pending.push_back(queue_step(c, s, t));
    endtask

    // Result checker and receiver stalls.
    always @(posedge clk)
    begin
        outcome_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result word status=%0d", status);
            end
            else
            begin
                e = pending.pop_front();
                if (status !== e.status || out_sector !== e.sector ||
                    out_tag !== e.tag || count !== e.count)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp %0d %h %h %0d got %0d %h %h %0d",
                                 e.status, e.sector, e.tag, e.count,
                                 status, out_sector, out_tag, count);
                end
            end
        end
        out_ready <= calm || ($urandom_range(99) >= STALL_PCT);
    end

    // Watchdog on cycles with no word accepted on either side.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    function automatic logic [SECTOR_W-1:0] rand_sector();
        return SECTOR_W'({$urandom(), $urandom()});
    endfunction

    task automatic test_empty_cases();
        send_word(CMD_DISP, '0, '0);          // dispatch from empty
        send_word(CMD_REM, '0, 8'h5A);        // remove absent tag
        send_word(CMD_UNUSED, '1, '1);        // unused command
    endtask

    task automatic test_field_extremes();
        send_word(CMD_ADD, '1, '1);
        send_word(CMD_ADD, '0, '0);
        send_word(CMD_ADD, 48'h800000000000, 8'h80);
        send_word(CMD_DISP, '0, '0);
        send_word(CMD_ADD, 48'h800000000000, 8'h11);   // equal to a queued sector: after it
        send_word(CMD_ADD, 48'h000000000001, 8'h22);   // just above head: front
        send_word(CMD_ADD, 48'h900000000000, 8'h80);   // duplicate tag
        send_word(CMD_REM, '0, 8'h80);                  // drops the front one
        repeat (6) send_word(CMD_DISP, '0, '0);
    endtask

    task automatic test_full_queue();
        repeat (QUEUE_DEPTH + 2) send_word(CMD_ADD, rand_sector(), 8'($urandom));
        repeat (QUEUE_DEPTH + 1) send_word(CMD_DISP, '0, '0);
    endtask

    // Mostly adds and dispatches around a moving head; sectors often cluster
    // near it so equal and neighbouring values occur.
    task automatic test_random_traffic(int n);
        logic [SECTOR_W-1:0] s;
        int                  k;
        for (int i = 0; i < n; i++)
        begin
            calm = (i >= n / 3 && i < n / 2);
            k = $urandom_range(99);
            case ($urandom_range(3))
                0: s = rand_sector();
                1: s = head_pos + SECTOR_W'($urandom_range(8)) - 48'd4;
                2: s = SECTOR_W'($urandom_range(63));
                default: s = '1 - SECTOR_W'($urandom_range(15));
            endcase
            if (k < 50) send_word(CMD_ADD, s, 8'($urandom_range(31) * (i % 8 + 1)));
            else if (k < 82) send_word(CMD_DISP, rand_sector(), 8'($urandom));
            else if (k < 97) send_word(CMD_REM, s, 8'($urandom_range(255)));
            else send_word(CMD_UNUSED, s, 8'($urandom));
        end
        calm = 1'b0;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_cases();
        test_field_extremes();
        test_full_queue();
        test_random_traffic(850);
        in_valid <= 1'b0;
        while (pending.size() != 0) @(posedge clk);
        repeat (2 * QUEUE_DEPTH + 10) @(posedge clk);
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
